[design/lcg_pkg.sv]
// ----------------------------------------------------------------------------
// lcg_pkg
// Shared constants and codes for the linear congruential generator.
// ----------------------------------------------------------------------------
package lcg_pkg;

  localparam int DATA_W    = 32;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [DATA_W-1:0] MULT_RST = 32'd16807;
  localparam logic [DATA_W-1:0] INCR_RST = 32'd0;
  localparam logic [DATA_W-1:0] MOD_RST  = 32'd2147483647;

  typedef enum logic [CMD_W-1:0] {
    CMD_NEXT    = 2'd0,
    CMD_SEED    = 2'd1,
    CMD_DISCARD = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MULT = 2'd0,
    CFG_INCR = 2'd1,
    CFG_MOD  = 2'd2
  } cfg_idx_e;

endpackage

[design/lcg_ifs.sv]
// ----------------------------------------------------------------------------
// lcg channel interfaces
// Command channel and number channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lcg_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [lcg_pkg::CMD_W-1:0]   cmd;
  logic [lcg_pkg::DATA_W-1:0]  operand;

  modport source (output valid, output cmd, output operand, input ready);
  modport sink (input valid, input cmd, input operand, output ready);
endinterface

interface lcg_num_if;
  logic                        valid;
  logic                        ready;
  logic [lcg_pkg::DATA_W-1:0]  number;

  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface

[design/lcg_mulmod.sv]
// ----------------------------------------------------------------------------
// lcg_mulmod
// Shared unit: (x*y + z) mod m, a multiply, an add, then a
// restoring shift-subtract reduction of one dividend bit per cycle.
// ----------------------------------------------------------------------------
module lcg_mulmod #(
  parameter int W = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] x_i,
  input  logic [W-1:0] y_i,
  input  logic [W-1:0] z_i,
  input  logic [W:0]   mod_i,
  output logic         done_o,
  output logic [W-1:0] res_o
);

  localparam int CW = $clog2(2 * W);
  localparam logic [CW-1:0] LAST = CW'(2 * W - 1);

  typedef enum logic [1:0] {
    M_IDLE,
    M_ADD,
    M_RED
  } mm_state_e;

  mm_state_e       state_q;
  logic [CW-1:0]   cnt_q;
  logic            done_q;
  logic [2*W-1:0]  p_q;
  logic [W-1:0]    z_q;
  logic [W:0]      m_q;
  logic [W:0]      r_q;

  logic [2*W-1:0]  prod;
  logic [W+1:0]    r_sh;
  logic [W+1:0]    r_sub;
  logic [W:0]      r_nxt;

  assign prod  = x_i * y_i;
  assign r_sh  = {r_q, p_q[2*W-1]};
  assign r_sub = r_sh - {1'b0, m_q};
  assign r_nxt = (r_sh >= {1'b0, m_q}) ? r_sub[W:0] : r_sh[W:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        M_IDLE: begin
          if (start_i) begin
            state_q <= M_ADD;
          end
        end
        M_ADD: begin
          cnt_q   <= '0;
          state_q <= M_RED;
        end
        M_RED: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LAST) begin
            state_q <= M_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      M_IDLE: begin
        if (start_i) begin
          p_q <= prod;
          z_q <= z_i;
          m_q <= mod_i;
        end
      end
      M_ADD: begin
        p_q <= p_q + {{W{1'b0}}, z_q};
        r_q <= '0;
      end
      M_RED: begin
        r_q <= r_nxt;
        p_q <= {p_q[2*W-2:0], 1'b0};
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = r_q[W-1:0];

endmodule

[design/lcg_generator_unit.sv]
// ----------------------------------------------------------------------------
// lcg_generator_unit
// Linear congruential generator, state = (a*state + c) mod m, with seed
// load and jump-ahead discard. All modular work runs on one shared unit.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_if carries one request (cmd, operand); num_if returns one number per
//   request, the generator state after the command. Requests are taken only
//   while the sequencer is idle, one at a time.
//   Multiplier, increment and modulus are written through cfg_we_i /
//   cfg_idx_i / cfg_data_i while no request is in flight; a modulus of zero
//   stands for 2^WIDTH.
//   Every modular operation runs on the shared mulmod unit, whose reduction
//   is a bit-serial shift-subtract.
//   next: one operation.
//   seed: two reductions (increment and seed).
//   discard n: three setup operations, up to five per bit of n up to its
//   highest set bit, and two final ones; a count of zero and an unused
//   command answer without using the shared unit.
//   Reset loads the default register values and a state of 1.
//   The result sits in an output register; a stalled receiver holds it
//   there, and the next request is still taken meanwhile but cannot finish
//   until the register is free.
// ----------------------------------------------------------------------------
module lcg_generator_unit #(
  parameter int WIDTH       = 32,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lcg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lcg_pkg::DATA_W-1:0]    cfg_data_i,
  lcg_cmd_if.sink                       cmd_if,
  lcg_num_if.source                     num_if
);

  localparam int NW = (COUNT_WIDTH < lcg_pkg::DATA_W) ? COUNT_WIDTH : lcg_pkg::DATA_W;
  localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_OUT
  } state_e;

  typedef enum logic [3:0] {
    PH_NEXT,
    PH_SEED_C,
    PH_SEED_S,
    PH_J_BA,
    PH_J_BC,
    PH_J_RA,
    PH_J_RA_UPD,
    PH_J_RC_UPD,
    PH_J_T,
    PH_J_BC_UPD,
    PH_J_BA_UPD,
    PH_J_SR,
    PH_J_FIN
  } phase_e;

  state_e                     state_q, state_d;
  phase_e                     phase_q, phase_d;
  logic                       out_valid_q, out_valid_d;
  logic [lcg_pkg::DATA_W-1:0] number_q, number_d;
  logic [WIDTH-1:0]           cur_q, cur_d;

  logic [WIDTH-1:0] mult_q, incr_q, mod_q;
  logic [WIDTH-1:0] seed_q, seed_d;
  logic [NW-1:0]    cnt_q, cnt_d;
  logic [WIDTH-1:0] ra_q, ra_d, rc_q, rc_d, ba_q, ba_d, bc_q, bc_d, tmp_q, tmp_d;
  logic             czero_q, czero_d;

  logic [WIDTH:0]   mod_eff;
  logic [WIDTH-1:0] mm_x, mm_y, mm_z, mm_res;
  logic             mm_start, mm_done;
  logic [NW-1:0]    cnt_shift;

  function automatic phase_e loop_phase(logic [NW-1:0] n);
    if (n == '0) begin
      return PH_J_SR;
    end else if (n[0]) begin
      return PH_J_RA_UPD;
    end
    return PH_J_T;
  endfunction

  // zero modulus means 2^WIDTH
  assign mod_eff   = (mod_q == '0) ? {1'b1, {WIDTH{1'b0}}} : {1'b0, mod_q};
  assign cnt_shift = cnt_q >> 1;
  assign mm_start  = (state_q == S_ISSUE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_q <= WIDTH'(lcg_pkg::MULT_RST);
      incr_q <= WIDTH'(lcg_pkg::INCR_RST);
      mod_q  <= WIDTH'(lcg_pkg::MOD_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lcg_pkg::CFG_MULT: mult_q <= cfg_data_i[WIDTH-1:0];
        lcg_pkg::CFG_INCR: incr_q <= cfg_data_i[WIDTH-1:0];
        lcg_pkg::CFG_MOD:  mod_q  <= cfg_data_i[WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // operands of the shared unit: result = (x*y + z) mod m
  always_comb begin
    mm_x = ONE;
    mm_y = ONE;
    mm_z = '0;
    unique case (phase_q)
      PH_NEXT: begin
        mm_x = mult_q;
        mm_y = cur_q;
        mm_z = incr_q;
      end
      PH_SEED_C:   mm_x = incr_q;
      PH_SEED_S:   mm_x = seed_q;
      PH_J_BA:     mm_x = mult_q;
      PH_J_BC:     mm_x = incr_q;
      PH_J_RA:     mm_x = ONE;
      PH_J_RA_UPD: begin
        mm_x = ra_q;
        mm_y = ba_q;
      end
      PH_J_RC_UPD: begin
        mm_x = rc_q;
        mm_y = ba_q;
        mm_z = bc_q;
      end
      PH_J_T: begin
        mm_x = ba_q;
        mm_z = ONE;
      end
      PH_J_BC_UPD: begin
        mm_x = bc_q;
        mm_y = tmp_q;
      end
      PH_J_BA_UPD: begin
        mm_x = ba_q;
        mm_y = ba_q;
      end
      PH_J_SR:     mm_x = cur_q;
      PH_J_FIN: begin
        mm_x = ra_q;
        mm_y = tmp_q;
        mm_z = rc_q;
      end
      default: ;
    endcase
  end

  lcg_mulmod #(
    .W (WIDTH)
  ) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .x_i     (mm_x),
    .y_i     (mm_y),
    .z_i     (mm_z),
    .mod_i   (mod_eff),
    .done_o  (mm_done),
    .res_o   (mm_res)
  );

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    number_d    = number_q;
    cur_d       = cur_q;
    seed_d      = seed_q;
    cnt_d       = cnt_q;
    ra_d        = ra_q;
    rc_d        = rc_q;
    ba_d        = ba_q;
    bc_d        = bc_q;
    tmp_d       = tmp_q;
    czero_d     = czero_q;

    if (out_valid_q && num_if.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (cmd_if.valid) begin
          unique case (cmd_if.cmd)
            lcg_pkg::CMD_NEXT: begin
              phase_d = PH_NEXT;
              state_d = S_ISSUE;
            end
            lcg_pkg::CMD_SEED: begin
              seed_d  = cmd_if.operand[WIDTH-1:0];
              phase_d = PH_SEED_C;
              state_d = S_ISSUE;
            end
            lcg_pkg::CMD_DISCARD: begin
              cnt_d = cmd_if.operand[NW-1:0];
              if (cmd_if.operand[NW-1:0] == '0) begin
                state_d = S_OUT;
              end else begin
                phase_d = PH_J_BA;
                state_d = S_ISSUE;
              end
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      S_ISSUE: state_d = S_WAIT;
      S_WAIT: begin
        if (mm_done) begin
          state_d = S_ISSUE;
          unique case (phase_q)
            PH_NEXT: begin
              cur_d   = mm_res;
              state_d = S_OUT;
            end
            PH_SEED_C: begin
              czero_d = (mm_res == '0);
              phase_d = PH_SEED_S;
            end
            PH_SEED_S: begin
              // keep a zero-increment generator from locking at zero
              cur_d   = (czero_q && mm_res == '0) ? ONE : seed_q;
              state_d = S_OUT;
            end
            PH_J_BA: begin
              ba_d    = mm_res;
              phase_d = PH_J_BC;
            end
            PH_J_BC: begin
              bc_d    = mm_res;
              phase_d = PH_J_RA;
            end
            PH_J_RA: begin
              ra_d    = mm_res;
              rc_d    = '0;
              phase_d = loop_phase(cnt_q);
            end
            PH_J_RA_UPD: begin
              ra_d    = mm_res;
              phase_d = PH_J_RC_UPD;
            end
            PH_J_RC_UPD: begin
              rc_d    = mm_res;
              phase_d = PH_J_T;
            end
            PH_J_T: begin
              tmp_d   = mm_res;
              phase_d = PH_J_BC_UPD;
            end
            PH_J_BC_UPD: begin
              bc_d    = mm_res;
              phase_d = PH_J_BA_UPD;
            end
            PH_J_BA_UPD: begin
              ba_d    = mm_res;
              cnt_d   = cnt_shift;
              phase_d = loop_phase(cnt_shift);
            end
            PH_J_SR: begin
              tmp_d   = mm_res;
              phase_d = PH_J_FIN;
            end
            PH_J_FIN: begin
              cur_d   = mm_res;
              state_d = S_OUT;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_OUT: begin
        if (!out_valid_q || num_if.ready) begin
          out_valid_d = 1'b1;
          number_d    = lcg_pkg::DATA_W'(cur_q);
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_NEXT;
      out_valid_q <= 1'b0;
      number_q    <= '0;
      cur_q       <= ONE;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      number_q    <= number_d;
      cur_q       <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seed_q  <= seed_d;
    cnt_q   <= cnt_d;
    ra_q    <= ra_d;
    rc_q    <= rc_d;
    ba_q    <= ba_d;
    bc_q    <= bc_d;
    tmp_q   <= tmp_d;
    czero_q <= czero_d;
  end

  assign cmd_if.ready  = (state_q == S_IDLE);
  assign num_if.valid  = out_valid_q;
  assign num_if.number = number_q;

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_if.valid && cmd_if.ready |=> !cmd_if.ready)
    else $error("request accepted while previous one in flight");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_done |-> state_q == S_WAIT)
    else $error("mulmod result with no waiting sequencer");

  a_next_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WAIT && mm_done && phase_q == PH_NEXT |=> {1'b0, cur_q} < mod_eff)
    else $error("next state not below modulus");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT && out_valid_q && !num_if.ready |=> state_q == S_OUT)
    else $error("result overwrote a stalled output");

endmodule
